[rtl/mtgp_pkg.sv]
package mtgp_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int CMD_DEPTH       = 4;
    localparam int RES_DEPTH       = 4;

    // command codes from the parser to the executor
    localparam logic [2:0] OP_NOP     = 3'd0;
    localparam logic [2:0] OP_DRAW    = 3'd1;
    localparam logic [2:0] OP_NEWLINE = 3'd2;
    localparam logic [2:0] OP_RESTORE = 3'd3;
    localparam logic [2:0] OP_SET_FG  = 3'd4;
    localparam logic [2:0] OP_SET_BG  = 3'd5;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_CHAR_ADV = 2'd0;
    localparam logic [1:0] REG_LINE_ADV = 2'd1;
    localparam logic [1:0] REG_DEF_FG   = 2'd2;
    localparam logic [1:0] REG_DEF_BG   = 2'd3;

    localparam logic [7:0]  CHAR_ADV_RST = 8'd8;
    localparam logic [7:0]  LINE_ADV_RST = 8'd8;
    localparam logic [31:0] DEF_FG_RST   = 32'hFFFF_FFFF;
    localparam logic [31:0] DEF_BG_RST   = 32'h0000_00FF;

    localparam logic RES_GLYPH  = 1'b0;
    localparam logic RES_REPORT = 1'b1;

    typedef struct packed {
        logic [7:0]  char_advance;
        logic [7:0]  line_advance;
        logic [31:0] default_fg;
        logic [31:0] default_bg;
    } cfg_t;

    typedef struct packed {
        logic [2:0]         op;
        logic [7:0]         glyph;
        logic [31:0]        color;
        logic               first;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic               eos;
    } cmd_t;

    typedef struct packed {
        logic               kind;
        logic [7:0]         glyph;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [31:0]        fg;
        logic [31:0]        bg;
        logic               last;
    } res_t;

endpackage

[rtl/markup_text_glyph_parser_unit.sv]
// Markup text parser: takes one string byte per clock unless full and returns glyph draw
// requests (glyph, position, foreground/background RGBA) plus a final cursor report on
// the byte flagged end_of_string. A parser front end turns bytes into commands and feeds
// a 4-entry command queue; the executor behind it owns cursor and colours and writes one
// result per cycle, when neither queue stalls it, into a 4-entry result queue. Sustained
// rate is one byte per cycle; a byte that both draws and ends the string holds the
// executor for a deferred cursor report because the result queue has a single write
// port. Registers: char_advance 0x0, line_advance 0x4, default_fg_color 0x8,
// default_bg_color 0xC; change them only while the block is idle.
module markup_text_glyph_parser_unit #(
    parameter int COORD_WIDTH = mtgp_pkg::COORD_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         text_byte,
    input  logic               first_byte,
    input  logic signed [15:0] start_x,
    input  logic signed [15:0] start_y,
    input  logic               end_of_string,
    output logic               empty,
    input  logic               pop,
    output logic               result_kind,
    output logic [7:0]         glyph_code,
    output logic signed [15:0] pos_x,
    output logic signed [15:0] pos_y,
    output logic [31:0]        fg_color,
    output logic [31:0]        bg_color,
    output logic               last_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    mtgp_pkg::cfg_t cfg_reg;
    mtgp_pkg::cmd_t cmd_in, cmd_out;
    mtgp_pkg::res_t res_in, res_out;
    logic           take, cmd_full, cmd_empty, cmd_pop;
    logic           res_full, res_push;
    logic           wr_req;

    assign pready = 1'b1;
    assign wr_req = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.char_advance <= mtgp_pkg::CHAR_ADV_RST;
            cfg_reg.line_advance <= mtgp_pkg::LINE_ADV_RST;
            cfg_reg.default_fg   <= mtgp_pkg::DEF_FG_RST;
            cfg_reg.default_bg   <= mtgp_pkg::DEF_BG_RST;
        end
        else if (wr_req)
        begin
            unique case (paddr[3:2])
                mtgp_pkg::REG_CHAR_ADV: cfg_reg.char_advance <= pwdata[7:0];
                mtgp_pkg::REG_LINE_ADV: cfg_reg.line_advance <= pwdata[7:0];
                mtgp_pkg::REG_DEF_FG:   cfg_reg.default_fg   <= pwdata;
                mtgp_pkg::REG_DEF_BG:   cfg_reg.default_bg   <= pwdata;
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            mtgp_pkg::REG_CHAR_ADV: prdata = 32'(cfg_reg.char_advance);
            mtgp_pkg::REG_LINE_ADV: prdata = 32'(cfg_reg.line_advance);
            mtgp_pkg::REG_DEF_FG:   prdata = cfg_reg.default_fg;
            mtgp_pkg::REG_DEF_BG:   prdata = cfg_reg.default_bg;
            default:                prdata = '0;
        endcase
    end

    assign full = cmd_full;
    assign take = push && !cmd_full;

    mtgp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .text_byte     (text_byte),
        .first_byte    (first_byte),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_of_string (end_of_string),
        .cmd           (cmd_in)
    );

    mtgp_fifo #(
        .WIDTH ($bits(mtgp_pkg::cmd_t)),
        .DEPTH (mtgp_pkg::CMD_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (take),
        .wr_data (cmd_in),
        .rd_en   (cmd_pop),
        .rd_data (cmd_out),
        .full    (cmd_full),
        .empty   (cmd_empty)
    );

    mtgp_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (cmd_out),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    mtgp_fifo #(
        .WIDTH ($bits(mtgp_pkg::res_t)),
        .DEPTH (mtgp_pkg::RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .rd_en   (pop),
        .rd_data (res_out),
        .full    (res_full),
        .empty   (empty)
    );

    assign result_kind = res_out.kind;
    assign glyph_code  = res_out.glyph;
    assign pos_x       = res_out.pos_x;
    assign pos_y       = res_out.pos_y;
    assign fg_color    = res_out.fg;
    assign bg_color    = res_out.bg;
    assign last_result = res_out.last;

    a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result written into a full queue");

    a_cmd_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("command taken from an empty queue");

    a_last_is_report: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last_result) |-> (result_kind == mtgp_pkg::RES_REPORT))
        else $error("last flag on a glyph request");

    a_report_no_glyph: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind == mtgp_pkg::RES_REPORT) |-> (glyph_code == 8'd0))
        else $error("cursor report carries a glyph code");

endmodule

[rtl/mtgp_fifo.sv]
module mtgp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/mtgp_front.sv]
module mtgp_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  logic [7:0]         text_byte,
    input  logic               first_byte,
    input  logic signed [15:0] start_x,
    input  logic signed [15:0] start_y,
    input  logic               end_of_string,
    output mtgp_pkg::cmd_t     cmd
);

    localparam logic [2:0] PH_TEXT  = 3'd0;
    localparam logic [2:0] PH_ESC   = 3'd1;
    localparam logic [2:0] PH_FG    = 3'd2;
    localparam logic [2:0] PH_BG    = 3'd3;
    localparam logic [2:0] PH_GLYPH = 3'd4;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOT = 8'h22;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QMARK = 8'h3F;

    logic [2:0]  phase_reg, phase_next, phase_cur;
    logic [2:0]  count_reg, count_next, count_cur;
    logic [3:0]  high_reg, high_next;
    logic [23:0] accum_reg, accum_next;

    logic signed [8:0] dig_s;
    logic [7:0]        dig;
    logic [7:0]        chan;

    // byte read as signed; letters above '9' fold down by 7
    always_comb
    begin
        dig_s = $signed({text_byte[7], text_byte}) - 9'sd48;
        if (dig_s > 9'sd9)
        begin
            dig_s = dig_s - 9'sd7;
        end
        dig = dig_s[7:0];
    end

    assign chan = {high_reg, 4'b0000} + dig;

    always_comb
    begin
        phase_cur  = first_byte ? PH_TEXT : phase_reg;
        count_cur  = first_byte ? 3'd0 : count_reg;
        phase_next = phase_cur;
        count_next = count_cur;
        high_next  = high_reg;
        accum_next = accum_reg;

        cmd         = '0;
        cmd.op      = mtgp_pkg::OP_NOP;
        cmd.glyph   = text_byte;
        cmd.color   = {accum_reg, chan};
        cmd.first   = first_byte;
        cmd.start_x = start_x;
        cmd.start_y = start_y;
        cmd.eos     = end_of_string;

        unique case (phase_cur) inside
            PH_ESC:
            begin
                phase_next = PH_TEXT;
                if (text_byte == CH_HASH)
                begin
                    cmd.op = mtgp_pkg::OP_DRAW;
                end
                else if (text_byte == CH_QUOTE)
                begin
                    cmd.op    = mtgp_pkg::OP_DRAW;
                    cmd.glyph = CH_DQUOT;
                end
                else if (text_byte == CH_N)
                begin
                    cmd.op = mtgp_pkg::OP_NEWLINE;
                end
                else if (text_byte == CH_C)
                begin
                    phase_next = PH_FG;
                    count_next = 3'd0;
                    accum_next = '0;
                end
                else if (text_byte == CH_B)
                begin
                    phase_next = PH_BG;
                    count_next = 3'd0;
                    accum_next = '0;
                end
                else if (text_byte == CH_QMARK)
                begin
                    phase_next = PH_GLYPH;
                    count_next = 3'd0;
                    accum_next = '0;
                end
                else if (text_byte == CH_BANG)
                begin
                    cmd.op = mtgp_pkg::OP_RESTORE;
                end
            end
            PH_FG, PH_BG, PH_GLYPH:
            begin
                if (!count_cur[0])
                begin
                    high_next  = dig[3:0];
                    count_next = count_cur + 3'd1;
                end
                else if (phase_cur == PH_GLYPH)
                begin
                    phase_next = PH_TEXT;
                    count_next = 3'd0;
                    cmd.op     = mtgp_pkg::OP_DRAW;
                    cmd.glyph  = chan;
                end
                else if (count_cur == 3'd7)
                begin
                    cmd.op     = (phase_cur == PH_FG) ? mtgp_pkg::OP_SET_FG
                                                      : mtgp_pkg::OP_SET_BG;
                    phase_next = PH_TEXT;
                    count_next = 3'd0;
                    accum_next = '0;
                end
                else
                begin
                    accum_next = {accum_reg[15:0], chan};
                    count_next = count_cur + 3'd1;
                end
            end
            default:
            begin
                phase_next = PH_TEXT;
                if (text_byte == CH_HASH)
                begin
                    phase_next = PH_ESC;
                end
                else
                begin
                    cmd.op = mtgp_pkg::OP_DRAW;
                end
            end
        endcase

        // an unfinished escape dies with the string
        if (end_of_string)
        begin
            phase_next = PH_TEXT;
            count_next = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TEXT;
            count_reg <= 3'd0;
            high_reg  <= '0;
            accum_reg <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            high_reg  <= high_next;
            accum_reg <= accum_next;
        end
    end

endmodule

[rtl/mtgp_back.sv]
module mtgp_back #(
    parameter int COORD_WIDTH = mtgp_pkg::COORD_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  mtgp_pkg::cfg_t   cfg,
    input  mtgp_pkg::cmd_t   cmd,
    input  logic             cmd_empty,
    output logic             cmd_pop,
    input  logic             res_full,
    output logic             res_push,
    output mtgp_pkg::res_t   res
);

    logic [COORD_WIDTH-1:0] cx_reg, cx_next, cy_reg, cy_next, ox_reg, ox_next;
    logic [COORD_WIDTH-1:0] ax, ay, ao;
    logic [31:0]            fg_reg, fg_next, bg_reg, bg_next, afg, abg;
    logic                   pend_reg, pend_next;
    logic                   is_draw;

    assign is_draw = (cmd.op == mtgp_pkg::OP_DRAW);
    assign cmd_pop = !pend_reg && !cmd_empty && !res_full;

    always_comb
    begin
        // first byte reloads the string context before the command runs
        ax  = cmd.first ? COORD_WIDTH'(cmd.start_x) : cx_reg;
        ay  = cmd.first ? COORD_WIDTH'(cmd.start_y) : cy_reg;
        ao  = cmd.first ? COORD_WIDTH'(cmd.start_x) : ox_reg;
        afg = cmd.first ? cfg.default_fg : fg_reg;
        abg = cmd.first ? cfg.default_bg : bg_reg;

        cx_next = ax;
        cy_next = ay;
        ox_next = ao;
        fg_next = afg;
        bg_next = abg;

        unique case (cmd.op)
            mtgp_pkg::OP_DRAW:    cx_next = ax + COORD_WIDTH'(cfg.char_advance);
            mtgp_pkg::OP_NEWLINE:
            begin
                cx_next = ao;
                cy_next = ay + COORD_WIDTH'(cfg.line_advance);
            end
            mtgp_pkg::OP_RESTORE:
            begin
                fg_next = cfg.default_fg;
                bg_next = cfg.default_bg;
            end
            mtgp_pkg::OP_SET_FG:  fg_next = cmd.color;
            mtgp_pkg::OP_SET_BG:  bg_next = cmd.color;
            default:              ;
        endcase
    end

    always_comb
    begin
        pend_next = pend_reg;
        res_push  = 1'b0;
        res       = '0;
        if (pend_reg)
        begin
            // deferred cursor report after a drawing end byte
            res_push  = !res_full;
            res.kind  = mtgp_pkg::RES_REPORT;
            res.pos_x = 16'(cx_reg);
            res.pos_y = 16'(cy_reg);
            res.fg    = fg_reg;
            res.bg    = bg_reg;
            res.last  = 1'b1;
            if (!res_full)
            begin
                pend_next = 1'b0;
            end
        end
        else if (is_draw)
        begin
            res_push  = cmd_pop;
            res.kind  = mtgp_pkg::RES_GLYPH;
            res.glyph = cmd.glyph;
            res.pos_x = 16'(ax);
            res.pos_y = 16'(ay);
            res.fg    = afg;
            res.bg    = abg;
            if (cmd_pop && cmd.eos)
            begin
                pend_next = 1'b1;
            end
        end
        else
        begin
            res_push  = cmd_pop && cmd.eos;
            res.kind  = mtgp_pkg::RES_REPORT;
            res.pos_x = 16'(cx_next);
            res.pos_y = 16'(cy_next);
            res.fg    = fg_next;
            res.bg    = bg_next;
            res.last  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg   <= '0;
            cy_reg   <= '0;
            ox_reg   <= '0;
            fg_reg   <= mtgp_pkg::DEF_FG_RST;
            bg_reg   <= mtgp_pkg::DEF_BG_RST;
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (cmd_pop)
            begin
                cx_reg <= cx_next;
                cy_reg <= cy_next;
                ox_reg <= ox_next;
                fg_reg <= fg_next;
                bg_reg <= bg_next;
            end
        end
    end

endmodule

[tb/tb_markup_text_glyph_parser_unit.sv]
module tb_markup_text_glyph_parser_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_PHASES        = 6;
    localparam int ITEMS_PER_PHASE = 285;
    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_CYCLES     = 400;
    localparam int END_WAIT        = 200000;
    localparam int MAX_REPORTS     = 10;

    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_APOS    = 8'h27;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_NEWLINE = 8'h6E;
    localparam logic [7:0] CH_FG      = 8'h63;
    localparam logic [7:0] CH_BG      = 8'h62;
    localparam logic [7:0] CH_RESTORE = 8'h21;
    localparam logic [7:0] CH_GLYPH   = 8'h3F;

    localparam logic [2:0] PS_TEXT  = 3'd0;
    localparam logic [2:0] PS_ESC   = 3'd1;
    localparam logic [2:0] PS_FG    = 3'd2;
    localparam logic [2:0] PS_BG    = 3'd3;
    localparam logic [2:0] PS_GLYPH = 3'd4;

    typedef struct packed {
        logic [7:0]         text;
        logic               first;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic               eos;
    } text_item_t;

    typedef struct {
        text_item_t     item;
        logic           typed;
        mtgp_pkg::res_t res;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [7:0]         text_byte;
    logic               first_byte;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic               end_of_string;
    logic               empty;
    logic               pop;
    logic               result_kind;
    logic [7:0]         glyph_code;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [31:0]        fg_color;
    logic [31:0]        bg_color;
    logic               last_result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    markup_text_glyph_parser_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .text_byte     (text_byte),
        .first_byte    (first_byte),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_of_string (end_of_string),
        .empty         (empty),
        .pop           (pop),
        .result_kind   (result_kind),
        .glyph_code    (glyph_code),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .fg_color      (fg_color),
        .bg_color      (bg_color),
        .last_result   (last_result),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // layout model
    mtgp_pkg::cfg_t model_cfg;
    logic [2:0]     ps;
    logic [2:0]     digit_cnt;
    logic [7:0]     hi_digit;
    logic [23:0]    col_acc;
    logic [15:0]    cur_x;
    logic [15:0]    cur_y;
    logic [15:0]    org_x;
    logic [31:0]    cur_fg;
    logic [31:0]    cur_bg;

    mtgp_pkg::res_t glyph_expect_q[$];
    text_item_t     markup_q[$];

    int err_cnt      = 0;
    int n_items      = 0;
    int n_glyph      = 0;
    int n_report     = 0;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int rx_hold_left = 0;

    dir_row_t dir_rows [32] = '{
        // corner origin, then the byte extremes
        '{'{8'h41, 1'b1, 16'sh8000, 16'sh7FFF, 1'b0}, 1'b1,
          {mtgp_pkg::RES_GLYPH, 8'h41, 16'h8000, 16'h7FFF,
           mtgp_pkg::DEF_FG_RST, mtgp_pkg::DEF_BG_RST, 1'b0}},
        '{'{8'h00, 1'b0, 16'sh0, 16'sh0, 1'b0}, 1'b1,
          {mtgp_pkg::RES_GLYPH, 8'h00, 16'h8008, 16'h7FFF,
           mtgp_pkg::DEF_FG_RST, mtgp_pkg::DEF_BG_RST, 1'b0}},
        '{'{8'hFF, 1'b0, 16'sh0, 16'sh0, 1'b0}, 1'b1,
          {mtgp_pkg::RES_GLYPH, 8'hFF, 16'h8010, 16'h7FFF,
           mtgp_pkg::DEF_FG_RST, mtgp_pkg::DEF_BG_RST, 1'b0}},
        '{'{CH_HASH, 1'b0, 16'sh0, 16'sh0, 1'b0}, 1'b0, '0},
        '{'{CH_HASH, 1'b0, 16'sh0, 16'sh0, 1'b0}, 1'b1,
          {mtgp_pkg::RES_GLYPH, CH_HASH, 16'h8018, 16'h7FFF,
           mtgp_pkg::DEF_FG_RST, mtgp_pkg::DEF_BG_RST, 1'b0}},
        '{'{CH_HASH, 1'b0, 16'sh0, 16'sh0, 1'b0}, 1'b0, '0},
        '{'{CH_APOS, 1'b0, 16'sh0, 16'sh0, 1'b0}, 1'b1,
          {mtgp_pkg::RES_GLYPH, CH_DQUOTE, 16'h8020, 16'h7FFF,
           mtgp_pkg::DEF_FG_RST, mtgp_pkg::DEF_BG_RST, 1'b0}},
        '{'{CH_HASH, 1'b0, 16'sh0, 16'sh0, 1'b0}, 1'b0, '0},
        '{'{CH_NEWLINE, 1'b0, 16'sh0, 16'sh0, 1'b0}, 1'b0, '0},
        // background from mixed-case and non-hex digits
        '{'{CH_HASH, 1'b0, 16'sh0, 16'sh0, 1'b0}, 1'b0, '0},
        '{'{CH_BG, 1'b0, 16'sh0, 16'sh0, 1'b0}, 1'b0, '0},
        '{'{8'h30, 1'b0, 16'sh0, 16'sh0, 1'b0}, 1'b0, '0},
        '{'{8'h46, 1'b0, 16'sh0, 16'sh0, 1'b0}, 1'b0, '0},
        '{'{8'h66, 1'b0, 16'sh0, 16'sh0, 1'b0}, 1'b0, '0},
        '{'{8'h39, 1'b0, 16'sh0, 16'sh0, 1'b0}, 1'b0, '0},
        '{'{8'h41, 1'b0, 16'sh0, 16'sh0, 1'b0}, 1'b0, '0},
        '{'{8'h7A, 1'b0, 16'sh0, 16'sh0, 1'b0}, 1'b0, '0},
        '{'{8'h80, 1'b0, 16'sh0, 16'sh0, 1'b0}, 1'b0, '0},
        '{'{8'h7F, 1'b0, 16'sh0, 16'sh0, 1'b0}, 1'b0, '0},
        // glyph by number
        '{'{CH_HASH, 1'b0, 16'sh0, 16'sh0, 1'b0}, 1'b0, '0},
        '{'{CH_GLYPH, 1'b0, 16'sh0, 16'sh0, 1'b0}, 1'b0, '0},
        '{'{8'h34, 1'b0, 16'sh0, 16'sh0, 1'b0}, 1'b0, '0},
        '{'{8'h31, 1'b0, 16'sh0, 16'sh0, 1'b0}, 1'b0, '0},
        '{'{CH_HASH, 1'b0, 16'sh0, 16'sh0, 1'b0}, 1'b0, '0},
        '{'{CH_RESTORE, 1'b0, 16'sh0, 16'sh0, 1'b0}, 1'b0, '0},
        // unknown escape, then a colour escape cut off by the end
        '{'{CH_HASH, 1'b0, 16'sh0, 16'sh0, 1'b0}, 1'b0, '0},
        '{'{8'h78, 1'b0, 16'sh0, 16'sh0, 1'b0}, 1'b0, '0},
        '{'{CH_HASH, 1'b0, 16'sh0, 16'sh0, 1'b0}, 1'b0, '0},
        '{'{CH_FG, 1'b0, 16'sh0, 16'sh0, 1'b0}, 1'b0, '0},
        '{'{8'h31, 1'b0, 16'sh0, 16'sh0, 1'b1}, 1'b0, '0},
        // continues past the end without a new start, draws and reports
        '{'{8'h5A, 1'b0, 16'sh0, 16'sh0, 1'b1}, 1'b0, '0},
        // one-byte string: escape opened and dropped at once
        '{'{CH_HASH, 1'b1, 16'sh7FFF, 16'sh8000, 1'b1}, 1'b1,
          {mtgp_pkg::RES_REPORT, 8'h00, 16'h7FFF, 16'h8000,
           mtgp_pkg::DEF_FG_RST, mtgp_pkg::DEF_BG_RST, 1'b1}}
    };

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic string fmt_res(mtgp_pkg::res_t r);
        return $sformatf("kind=%0d glyph=%02h x=%04h y=%04h fg=%08h bg=%08h last=%0d",
                         r.kind, r.glyph, r.pos_x, r.pos_y, r.fg, r.bg, r.last);
    endfunction

    task automatic report_error(string msg);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    function automatic logic [7:0] hex_value(logic [7:0] b);
        int d;
        d = int'($signed(b)) - 48;
        if (d > 9)
            d -= 7;
        return d[7:0];
    endfunction

    function automatic void queue_result(logic kind, logic [7:0] glyph, logic last);
        glyph_expect_q.push_back({kind, glyph, cur_x, cur_y, cur_fg, cur_bg, last});
    endfunction

    function automatic void queue_draw(logic [7:0] glyph);
        queue_result(mtgp_pkg::RES_GLYPH, glyph, 1'b0);
        cur_x = cur_x + 16'(model_cfg.char_advance);
    endfunction

    function automatic void predict_glyphs(text_item_t it);
        logic [7:0] d;
        logic [7:0] ch;
        if (it.first)
        begin
            cur_x     = it.sx;
            cur_y     = it.sy;
            org_x     = cur_x;
            cur_fg    = model_cfg.default_fg;
            cur_bg    = model_cfg.default_bg;
            ps        = PS_TEXT;
            digit_cnt = '0;
        end
        case (ps) inside
            PS_ESC:
            begin
                ps = PS_TEXT;
                if (it.text == CH_HASH)
                    queue_draw(CH_HASH);
                else if (it.text == CH_APOS)
                    queue_draw(CH_DQUOTE);
                else if (it.text == CH_NEWLINE)
                begin
                    cur_x = org_x;
                    cur_y = cur_y + 16'(model_cfg.line_advance);
                end
                else if (it.text == CH_FG || it.text == CH_BG || it.text == CH_GLYPH)
                begin
                    ps = (it.text == CH_FG) ? PS_FG : (it.text == CH_BG) ? PS_BG : PS_GLYPH;
                    digit_cnt = '0;
                    col_acc   = '0;
                end
                else if (it.text == CH_RESTORE)
                begin
                    cur_fg = model_cfg.default_fg;
                    cur_bg = model_cfg.default_bg;
                end
            end
            PS_FG, PS_BG, PS_GLYPH:
            begin
                d = hex_value(it.text);
                if (!digit_cnt[0])
                begin
                    hi_digit  = d;
                    digit_cnt = digit_cnt + 3'd1;
                end
                else
                begin
                    ch = {hi_digit[3:0], 4'b0} + d;
                    if (ps == PS_GLYPH)
                    begin
                        ps        = PS_TEXT;
                        digit_cnt = '0;
                        queue_draw(ch);
                    end
                    else if (digit_cnt == 3'd7)
                    begin
                        if (ps == PS_FG)
                            cur_fg = {col_acc, ch};
                        else
                            cur_bg = {col_acc, ch};
                        ps        = PS_TEXT;
                        digit_cnt = '0;
                        col_acc   = '0;
                    end
                    else
                    begin
                        col_acc   = {col_acc[15:0], ch};
                        digit_cnt = digit_cnt + 3'd1;
                    end
                end
            end
            default:
            begin
                ps = PS_TEXT;
                if (it.text == CH_HASH)
                    ps = PS_ESC;
                else
                    queue_draw(it.text);
            end
        endcase
        if (it.eos)
        begin
            queue_result(mtgp_pkg::RES_REPORT, 8'h00, 1'b1);
            ps        = PS_TEXT;
            digit_cnt = '0;
        end
    endfunction

    // one text request per accepted push
    task automatic push_text(text_item_t it);
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            push <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        push          <= 1'b1;
        text_byte     <= it.text;
        first_byte    <= it.first;
        start_x       <= it.sx;
        start_y       <= it.sy;
        end_of_string <= it.eos;
        do @(posedge clk); while (full);
        predict_glyphs(it);
        n_items++;
    endtask

    // wait out every result, then let trailing no-result bytes retire
    task automatic settle_parser();
        push <= 1'b0;
        while (glyph_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_layout_reg(logic [1:0] idx, logic [31:0] val);
        logic [31:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            mtgp_pkg::REG_CHAR_ADV: model_cfg.char_advance = val[7:0];
            mtgp_pkg::REG_LINE_ADV: model_cfg.line_advance = val[7:0];
            mtgp_pkg::REG_DEF_FG:   model_cfg.default_fg   = val;
            default:                model_cfg.default_bg   = val;
        endcase
        case (idx)
            mtgp_pkg::REG_CHAR_ADV: want = {24'h0, model_cfg.char_advance};
            mtgp_pkg::REG_LINE_ADV: want = {24'h0, model_cfg.line_advance};
            mtgp_pkg::REG_DEF_FG:   want = model_cfg.default_fg;
            default:                want = model_cfg.default_bg;
        endcase
        // back-to-back read of the same register
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
            report_error($sformatf("reg %0d readback exp %08h got %08h", idx, want, prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [7:0] rand_hex_char();
        int v;
        v = $urandom_range(0, 15);
        case ($urandom_range(0, 7)) inside
            0: return 8'($urandom_range(0, 255));
            [1:2]: if (v > 9) return 8'(87 + v);
            default: ;
        endcase
        return (v > 9) ? 8'(55 + v) : 8'(48 + v);
    endfunction

    // one random markup string into markup_q, mostly well formed
    task automatic compose_markup();
        logic [7:0] raw[$];
        logic [7:0] b;
        int         n_len;
        text_item_t it;
        raw = {};
        repeat ($urandom_range(1, 10))
        begin
            case ($urandom_range(0, 11)) inside
                [0:3]:
                begin
                    b = 8'($urandom_range(0, 255));
                    raw.push_back((b == CH_HASH) ? 8'h2E : b);
                end
                4:
                begin
                    raw.push_back(CH_HASH);
                    raw.push_back(CH_HASH);
                end
                5:
                begin
                    raw.push_back(CH_HASH);
                    raw.push_back(CH_APOS);
                end
                6:
                begin
                    raw.push_back(CH_HASH);
                    raw.push_back(CH_NEWLINE);
                end
                7:
                begin
                    raw.push_back(CH_HASH);
                    raw.push_back(CH_RESTORE);
                end
                [8:9]:
                begin
                    raw.push_back(CH_HASH);
                    raw.push_back($urandom_range(0, 1) ? CH_FG : CH_BG);
                    repeat (8) raw.push_back(rand_hex_char());
                end
                10:
                begin
                    raw.push_back(CH_HASH);
                    raw.push_back(CH_GLYPH);
                    repeat (2) raw.push_back(rand_hex_char());
                end
                default:
                begin
                    if ($urandom_range(0, 1))
                        raw.push_back(CH_HASH);
                    raw.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end
        n_len = raw.size();
        if ($urandom_range(0, 9) == 0)
            n_len = $urandom_range(1, raw.size());
        for (int i = 0; i < n_len; i++)
        begin
            it.text  = raw[i];
            it.sx    = 16'($urandom_range(0, 65535));
            it.sy    = 16'($urandom_range(0, 65535));
            it.first = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 99) < 3);
            it.eos   = (i == n_len - 1) || ($urandom_range(0, 99) < 3);
            markup_q.push_back(it);
        end
    endtask

    task automatic check_result();
        mtgp_pkg::res_t act;
        mtgp_pkg::res_t want;
        act = {result_kind, glyph_code, pos_x, pos_y, fg_color, bg_color, last_result};
        if (glyph_expect_q.size() == 0)
        begin
            report_error({"unexpected result ", fmt_res(act)});
        end
        else
        begin
            want = glyph_expect_q.pop_front();
            if (want.kind == mtgp_pkg::RES_REPORT)
                n_report++;
            else
                n_glyph++;
            if (act.kind !== want.kind || act.glyph !== want.glyph ||
                act.pos_x !== want.pos_x || act.pos_y !== want.pos_y ||
                act.fg !== want.fg || act.bg !== want.bg || act.last !== want.last)
                report_error({"mismatch\n  exp ", fmt_res(want), "\n  act ", fmt_res(act)});
        end
    endtask

    // result side
    initial
    begin
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
            @(posedge clk);
            if (pop && !empty)
                check_result();
        end
    end

    initial
    begin
        int          target;
        bit          paused;
        logic [31:0] v_ca;
        logic [31:0] v_la;
        logic [31:0] v_fg;
        logic [31:0] v_bg;

        rst_n         <= 1'b0;
        push          <= 1'b0;
        text_byte     <= '0;
        first_byte    <= 1'b0;
        start_x       <= '0;
        start_y       <= '0;
        end_of_string <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;

        model_cfg = '{mtgp_pkg::CHAR_ADV_RST, mtgp_pkg::LINE_ADV_RST,
                      mtgp_pkg::DEF_FG_RST, mtgp_pkg::DEF_BG_RST};
        ps        = PS_TEXT;
        digit_cnt = '0;
        hi_digit  = '0;
        col_acc   = '0;
        cur_x     = '0;
        cur_y     = '0;
        org_x     = '0;
        cur_fg    = mtgp_pkg::DEF_FG_RST;
        cur_bg    = mtgp_pkg::DEF_BG_RST;
        paused    = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < N_PHASES; p++)
        begin
            if (p > 0)
            begin
                settle_parser();
                if (p == 1)
                begin
                    v_ca = '0; v_la = '0; v_fg = '0; v_bg = '0;
                end
                else if (p == 2)
                begin
                    v_ca = 32'hFF; v_la = 32'hFF; v_fg = '1; v_bg = '1;
                end
                else
                begin
                    v_ca = $urandom_range(0, 255);
                    v_la = $urandom_range(0, 255);
                    v_fg = $urandom;
                    v_bg = $urandom;
                end
                write_layout_reg(mtgp_pkg::REG_CHAR_ADV, v_ca);
                write_layout_reg(mtgp_pkg::REG_LINE_ADV, v_la);
                write_layout_reg(mtgp_pkg::REG_DEF_FG, v_fg);
                write_layout_reg(mtgp_pkg::REG_DEF_BG, v_bg);
            end

            case (p / 2)
                0:
                begin
                    tx_idle_pct = 17;
                    rx_idle_pct = 82;
                end
                1:
                begin
                    tx_idle_pct = 82;
                    rx_idle_pct = 17;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase

            if (p == 0)
            begin
                foreach (dir_rows[i])
                begin
                    push_text(dir_rows[i].item);
                    if (dir_rows[i].typed)
                    begin
                        void'(glyph_expect_q.pop_back());
                        glyph_expect_q.push_back(dir_rows[i].res);
                    end
                end
            end

            // receiver stalls long enough to back the block up into full
            if (p == 4)
                rx_hold_left = HOLD_CYCLES;

            target = n_items + ITEMS_PER_PHASE;
            while (n_items < target)
            begin
                if (p == 3 && !paused && n_items >= target - ITEMS_PER_PHASE / 2)
                begin
                    settle_parser();
                    paused = 1'b1;
                end
                compose_markup();
                while (markup_q.size() != 0)
                    push_text(markup_q.pop_front());
            end
        end

        push <= 1'b0;
        for (int w = 0; w < END_WAIT && glyph_expect_q.size() != 0; w++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (glyph_expect_q.size() != 0)
            report_error($sformatf("%0d results never arrived", glyph_expect_q.size()));

        $display("Sent %0d text bytes under %0d register settings with sender and receiver stalls;",
                 n_items, N_PHASES);
        $display("checked %0d glyph draws and %0d cursor reports.", n_glyph, n_report);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
